@@ rtl/h2r_pkg.sv @@
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared types and codes for the HSL to RGB converter: hue segment codes,
// the per-colour segment set and the status word of the front/back queue.
// ----------------------------------------------------------------------------
package h2r_pkg;

   // Hue segment in which a channel's offset hue falls
   typedef logic [1:0] seg_type;

   localparam seg_type SEG_RISE = 2'd0;  // below one sixth: ramp up from p
   localparam seg_type SEG_HIGH = 2'd1;  // below one half: flat at q
   localparam seg_type SEG_FALL = 2'd2;  // below two thirds: ramp down to p
   localparam seg_type SEG_LOW  = 2'd3;  // rest of the turn: flat at p

   typedef struct packed {
      seg_type red;
      seg_type green;
      seg_type blue;
   } seg_set_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_stat_type;

   localparam int SEG_SET_W = $bits(seg_set_type);

   // Output scale: channels span 0 to 0xFF
   localparam int BYTE_W = 8;

endpackage

@@ rtl/h2r_front.sv @@
// ----------------------------------------------------------------------------
// h2r_front
// Takes one colour word, clamps saturation and lightness, wraps the hue,
// forms the three channel hue offsets, classifies each into its segment and
// precomputes the slope factor. Holds the word until the queue takes it.
// ----------------------------------------------------------------------------
module h2r_front #(
   parameter int FRAC_BITS = 16,
   localparam int ENTRY_W = h2r_pkg::SEG_SET_W + 3 * (FRAC_BITS + 3) + 2 * (FRAC_BITS + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_hue,
   input  logic [17:0]        req_saturation,
   input  logic [17:0]        req_lightness,
   input  logic               queue_full,
   output logic               push,
   output logic [ENTRY_W-1:0] push_data
);
   import h2r_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int W      = F + 1;
   localparam int FW     = F + 3;
   localparam int CW     = (W > 17) ? W : 17;
   localparam int ONE_I  = 1 << F;
   localparam int HALF_I = ONE_I / 2;
   localparam int SIXTH_I = (ONE_I + 3) / 6;
   localparam int THIRD_I = (ONE_I + 1) / 3;
   localparam int TT_I    = (2 * ONE_I + 1) / 3;

   logic               valid_ff, valid_in;
   logic [ENTRY_W-1:0] data_ff, data_in;
   logic               accept;

   logic [F-1:0]  hue_g, hue_r, hue_b;
   logic [W-1:0]  sat_c, light_c;
   logic [CW-1:0] sat_w, light_w;
   seg_set_type   segs;
   logic [FW-1:0] fac_r, fac_g, fac_b;

   function automatic seg_type classify(input logic [F-1:0] t);
      seg_type sg;
      if (t < F'(SIXTH_I)) begin
         sg = SEG_RISE;
      end else if (t < F'(HALF_I)) begin
         sg = SEG_HIGH;
      end else if (t < F'(TT_I)) begin
         sg = SEG_FALL;
      end else begin
         sg = SEG_LOW;
      end
      return sg;
   endfunction

   // Six times the distance into the ramp; zero on the flat segments
   function automatic logic [FW-1:0] slope(input logic [F-1:0] t, input seg_type sg);
      logic [FW-1:0] x;
      case (sg)
         SEG_RISE: begin
            x = FW'(t);
         end
         SEG_FALL: begin
            x = FW'(F'(TT_I) - t);
         end
         default: begin
            x = '0;
         end
      endcase
      return (x << 2) + (x << 1);
   endfunction

   always_comb begin
      sat_w   = CW'(req_saturation[16:0]);
      light_w = CW'(req_lightness[16:0]);
      // drop negatives to zero, cap at one
      sat_c   = req_saturation[17] ? '0 :
                (sat_w > CW'(ONE_I)) ? W'(ONE_I) : W'(sat_w);
      light_c = req_lightness[17] ? '0 :
                (light_w > CW'(ONE_I)) ? W'(ONE_I) : W'(light_w);

      hue_g = req_hue[F-1:0];
      hue_r = hue_g + F'(THIRD_I);
      hue_b = hue_g + F'(ONE_I - THIRD_I);

      segs.red   = classify(hue_r);
      segs.green = classify(hue_g);
      segs.blue  = classify(hue_b);

      fac_r = slope(hue_r, segs.red);
      fac_g = slope(hue_g, segs.green);
      fac_b = slope(hue_b, segs.blue);
   end

   assign busy   = valid_ff & queue_full;
   assign accept = start & ~busy;
   assign push   = valid_ff & ~queue_full;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = {segs, fac_r, fac_g, fac_b, sat_c, light_c};
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign push_data = data_ff;

endmodule

@@ rtl/h2r_queue.sv @@
// ----------------------------------------------------------------------------
// h2r_queue
// Two-word queue between the front and the back so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module h2r_queue #(
   parameter int DATA_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [DATA_W-1:0]       push_data,
   input  logic                    pop,
   output logic [DATA_W-1:0]       pop_data,
   output h2r_pkg::queue_stat_type stat
);
   import h2r_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign do_push        = push & ~stat.full;
   assign do_pop         = pop & stat.not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];

endmodule

@@ rtl/h2r_back.sv @@
// ----------------------------------------------------------------------------
// h2r_back
// Six-stage pipeline: l*s, q, p, slope products, segment select with
// saturation, and rounding to eight bits. Never stalls.
// ----------------------------------------------------------------------------
module h2r_back #(
   parameter int FRAC_BITS = 16,
   localparam int ENTRY_W = h2r_pkg::SEG_SET_W + 3 * (FRAC_BITS + 3) + 2 * (FRAC_BITS + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       entry_valid,
   input  logic [ENTRY_W-1:0]         entry,
   output logic                       rsp_valid,
   output logic [h2r_pkg::BYTE_W-1:0] rsp_red,
   output logic [h2r_pkg::BYTE_W-1:0] rsp_green,
   output logic [h2r_pkg::BYTE_W-1:0] rsp_blue
);
   import h2r_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int W      = F + 1;
   localparam int FW     = F + 3;
   localparam int SW     = W + 3;
   localparam int BW     = W + 9;
   localparam int STAGES = 6;
   localparam int ONE_I  = 1 << F;
   localparam int HALF_I = ONE_I / 2;
   localparam logic [W-1:0] ONE = W'(ONE_I);

   // lane 2 red, lane 1 green, lane 0 blue
   seg_set_type         e_seg;
   logic [2:0][FW-1:0]  e_fac;
   logic [W-1:0]        e_s, e_l;
   seg_type [2:0]       e_lane_seg;

   logic [STAGES-1:0]   vld_ff, vld_in;

   // stage 1
   logic [2*W-1:0]      ls_prod;
   logic [W-1:0]        ls1_ff, ls1_in, l1_ff, s1_ff;
   logic [2:0][FW-1:0]  fac1_ff;
   seg_type [2:0]       seg1_ff;
   // stage 2
   logic [W:0]          q_raw;
   logic [W-1:0]        q2_ff, q2_in, l2_ff;
   logic [2:0][FW-1:0]  fac2_ff;
   seg_type [2:0]       seg2_ff;
   // stage 3
   logic [W:0]          l_dbl, p_raw;
   logic [W-1:0]        p3_ff, p3_in, q3_ff;
   logic [2:0][FW-1:0]  fac3_ff;
   seg_type [2:0]       seg3_ff;
   // stage 4
   logic [W-1:0]        diff;
   logic [2:0][W+FW-1:0] prod;
   logic [2:0][SW-1:0]  sh4_ff, sh4_in;
   logic [W-1:0]        p4_ff, q4_ff;
   seg_type [2:0]       seg4_ff;
   // stage 5
   logic [2:0][SW:0]    pick;
   logic [2:0][W-1:0]  c5_ff, c5_in;
   // stage 6
   logic [2:0][BW-1:0]  scaled;
   logic [2:0][BYTE_W-1:0] byte_ff, byte_in;

   assign {e_seg, e_fac, e_s, e_l} = entry;
   assign e_lane_seg = {e_seg.red, e_seg.green, e_seg.blue};

   assign vld_in = {vld_ff[STAGES-2:0], entry_valid};

   always_comb begin
      ls_prod = (2 * W)'(e_l) * (2 * W)'(e_s);
      ls1_in  = W'(ls_prod >> F);

      // ls never exceeds l or s, so the upper branch cannot go negative
      if (l1_ff < W'(HALF_I)) begin
         q_raw = (W + 1)'(l1_ff) + (W + 1)'(ls1_ff);
      end else begin
         q_raw = (W + 1)'(l1_ff) + (W + 1)'(s1_ff) - (W + 1)'(ls1_ff);
      end
      q2_in = (q_raw > (W + 1)'(ONE)) ? ONE : W'(q_raw);

      l_dbl = (W + 1)'(l2_ff) << 1;
      p_raw = (l_dbl > (W + 1)'(q2_ff)) ? l_dbl - (W + 1)'(q2_ff) : '0;
      p3_in = (p_raw > (W + 1)'(q2_ff)) ? q2_ff : W'(p_raw);

      diff = q3_ff - p3_ff;
      for (int i = 0; i < 3; i++) begin
         prod[i]   = (W + FW)'(diff) * (W + FW)'(fac3_ff[i]);
         sh4_in[i] = SW'(prod[i] >> F);
      end

      for (int i = 0; i < 3; i++) begin
         case (seg4_ff[i])
            SEG_RISE, SEG_FALL: begin
               pick[i] = (SW + 1)'(p4_ff) + (SW + 1)'(sh4_ff[i]);
            end
            SEG_HIGH: begin
               pick[i] = (SW + 1)'(q4_ff);
            end
            default: begin
               pick[i] = (SW + 1)'(p4_ff);
            end
         endcase
         // cap the small overshoot left by rounded thresholds
         c5_in[i] = (pick[i] > (SW + 1)'(ONE)) ? ONE : W'(pick[i]);
      end

      for (int i = 0; i < 3; i++) begin
         scaled[i]  = ((BW'(c5_ff[i]) << 8) - BW'(c5_ff[i]) + BW'(HALF_I)) >> F;
         byte_in[i] = BYTE_W'(scaled[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      ls1_ff  <= ls1_in;
      l1_ff   <= e_l;
      s1_ff   <= e_s;
      fac1_ff <= e_fac;
      seg1_ff <= e_lane_seg;

      q2_ff   <= q2_in;
      l2_ff   <= l1_ff;
      fac2_ff <= fac1_ff;
      seg2_ff <= seg1_ff;

      p3_ff   <= p3_in;
      q3_ff   <= q2_ff;
      fac3_ff <= fac2_ff;
      seg3_ff <= seg2_ff;

      sh4_ff  <= sh4_in;
      p4_ff   <= p3_ff;
      q4_ff   <= q3_ff;
      seg4_ff <= seg3_ff;

      c5_ff   <= c5_in;
      byte_ff <= byte_in;
   end

   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_red   = byte_ff[2];
   assign rsp_green = byte_ff[1];
   assign rsp_blue  = byte_ff[0];

endmodule

@@ rtl/hsl_to_rgb_converter_core.sv @@
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_core
// Path: an accepted colour is held in the front word, passes the queue and the six back stages, then strobes rsp_valid.
// Throughput: one colour per cycle; the six-stage back pipeline drains the
// queue every cycle, so busy stays low in operation.
// Reset: synchronous; clears the front word, the queue pointers and all
// pipeline valid bits. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [31:0]                req_hue,
   input  logic [17:0]                req_saturation,
   input  logic [17:0]                req_lightness,
   output logic                       rsp_valid,
   output logic [h2r_pkg::BYTE_W-1:0] rsp_red,
   output logic [h2r_pkg::BYTE_W-1:0] rsp_green,
   output logic [h2r_pkg::BYTE_W-1:0] rsp_blue
);
   import h2r_pkg::*;

   localparam int ENTRY_W = SEG_SET_W + 3 * (FRAC_BITS + 3) + 2 * (FRAC_BITS + 1);

   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic [ENTRY_W-1:0] pop_data;
   logic               pop;
   queue_stat_type     qst;

   h2r_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_hue       (req_hue),
      .req_saturation(req_saturation),
      .req_lightness (req_lightness),
      .queue_full    (qst.full),
      .push          (push),
      .push_data     (push_data)
   );

   h2r_queue #(
      .DATA_W(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .stat     (qst)
   );

   // back end never stalls: take a word whenever one is waiting
   assign pop = qst.not_empty;

   h2r_back #(
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .entry_valid(pop),
      .entry      (pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

   a_pipe_latency: assert property (@(posedge clock) disable iff (reset)
      pop |-> ##6 rsp_valid)
      else $error("word taken from queue did not reach the result strobe");

   a_front_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (push || busy))
      else $error("accepted word neither pushed nor held");

   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(push_data))
      else $error("front word changed while busy");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      !qst.full)
      else $error("queue filled although the back end drains every cycle");

endmodule
